// ===== design/wcwes_pkg.sv =====
// Shared types and constants for the wheel command watchdog and ERPM frame sender.
// Holds operation and register codes, reset values and the controller/datapath
// command and status structs. No dependencies.
package wcwes_pkg;

    // Wheel count and the number of velocity inputs carried by a command
    localparam int WHEELS      = 4;
    localparam int VEL_INPUTS  = 4;
    localparam int WHEELS_USED = (WHEELS < VEL_INPUTS) ? WHEELS : VEL_INPUTS;
    localparam logic [1:0] LAST_WHEEL = 2'(WHEELS_USED - 1);

    // Field widths
    localparam int VEL_W   = 16;
    localparam int GAIN_W  = 24;
    localparam int MAX_W   = 31;
    localparam int PROD_W  = 40;
    localparam int ID_W    = 8;
    localparam int FRAME_ID_W = 29;

    // Rounding constant for the Q.16 product, half away from zero on the magnitude
    localparam logic [PROD_W-1:0] ROUND_HALF = 40'd32768;

    // Register reset values
    localparam logic [23:0] RST_ERPM_GAIN    = 24'd256;
    localparam logic [30:0] RST_MAX_ABS_ERPM = 31'd100000;
    localparam logic [31:0] RST_TIMEOUT_MS   = 32'd200;
    localparam logic [3:0]  RST_DIR_MASK     = 4'd0;
    localparam logic [31:0] RST_WHEEL_IDS    = 32'd0;
    localparam logic [7:0]  RST_PACKET_TYPE  = 8'd3;

    // Request operation codes
    typedef enum logic [1:0] {
        OP_NEW_CMD    = 2'd0,
        OP_INVALIDATE = 2'd1,
        OP_LINK       = 2'd2,
        OP_TICK       = 2'd3
    } op_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_ERPM_GAIN    = 3'd0,
        CFG_MAX_ABS_ERPM = 3'd1,
        CFG_TIMEOUT_MS   = 3'd2,
        CFG_DIR_MASK     = 3'd3,
        CFG_WHEEL_IDS    = 3'd4,
        CFG_PACKET_TYPE  = 3'd5
    } cfg_idx_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MUL  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       take;       // request accepted this cycle
        logic       mul;        // register the product for the current wheel
        logic       load;       // load the output register with a frame
        logic [1:0] wheel;      // current wheel
        logic       last;       // current wheel is the final one of the tick
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;         // output register can take a frame this cycle
    } dp_status_t;

endpackage

// ===== design/wcwes_ctrl.sv =====
// Controller for the wheel command watchdog and ERPM frame sender.
// Sequences one tick through a multiply and a finish step per wheel.
// Depends on wcwes_pkg.
module wcwes_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [1:0]             op,
    output logic                   in_ready,
    output wcwes_pkg::ctrl_cmd_t   cmd,
    input  wcwes_pkg::dp_status_t  status
);

    wcwes_pkg::state_t state_reg;
    wcwes_pkg::state_t state_next;
    logic [1:0]        wheel_reg;
    logic [1:0]        wheel_next;
    logic              take;
    logic              is_last;

    // Take requests only when no tick is in progress
    assign in_ready = (state_reg == wcwes_pkg::ST_IDLE);
    assign take     = in_valid & in_ready;
    assign is_last  = (wheel_reg == wcwes_pkg::LAST_WHEEL);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        wheel_next = wheel_reg;
        cmd.take   = take;
        cmd.mul    = 1'b0;
        cmd.load   = 1'b0;
        cmd.wheel  = wheel_reg;
        cmd.last   = is_last;
        case (state_reg)
            wcwes_pkg::ST_IDLE:
            begin
                if (take && (op == wcwes_pkg::OP_TICK))
                begin
                    state_next = wcwes_pkg::ST_MUL;
                    wheel_next = 2'd0;
                end
            end
            wcwes_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = wcwes_pkg::ST_FIN;
            end
            wcwes_pkg::ST_FIN:
            begin
                // Hold until the output register is free, then advance
                if (status.out_free)
                begin
                    cmd.load = 1'b1;
                    if (is_last)
                    begin
                        state_next = wcwes_pkg::ST_IDLE;
                    end
                    else
                    begin
                        wheel_next = wheel_reg + 2'd1;
                        state_next = wcwes_pkg::ST_MUL;
                    end
                end
            end
            default:
            begin
                state_next = wcwes_pkg::ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wcwes_pkg::ST_IDLE;
            wheel_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            wheel_reg <= wheel_next;
        end
    end

endmodule

// ===== design/wcwes_dp.sv =====
// Datapath for the wheel command watchdog and ERPM frame sender.
// Holds configuration, the stored command, the scaling multiplier and the
// output frame register. Depends on wcwes_pkg.
module wcwes_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  wcwes_pkg::ctrl_cmd_t   cmd,
    output wcwes_pkg::dp_status_t  status,
    input  logic [1:0]             op,
    input  logic signed [15:0]     velocity_0,
    input  logic signed [15:0]     velocity_1,
    input  logic signed [15:0]     velocity_2,
    input  logic signed [15:0]     velocity_3,
    input  logic                   command_valid,
    input  logic                   link_up,
    input  logic [31:0]            now_ms,
    input  logic                   motion_allowed,
    input  logic                   relay_stopping,
    input  logic                   cfg_valid,
    input  logic [2:0]             cfg_index,
    input  logic [31:0]            cfg_data,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [28:0]            frame_id,
    output logic [31:0]            frame_data,
    output logic signed [31:0]     signed_erpm,
    output logic [1:0]             wheel_index,
    output logic                   zero_cycle_note,
    output logic [31:0]            rejected_count,
    output logic                   last
);

    // Configuration registers
    logic [wcwes_pkg::GAIN_W-1:0] gain_reg;
    logic [wcwes_pkg::MAX_W-1:0]  max_reg;
    logic [31:0]                  timeout_reg;
    logic [3:0]                   dir_reg;
    logic [31:0]                  ids_reg;
    logic [7:0]                   ptype_reg;

    // Command state
    logic [wcwes_pkg::VEL_W-1:0]  vel_reg [wcwes_pkg::VEL_INPUTS];
    logic [31:0]                  time_reg;
    logic                         received_reg;
    logic                         ok_reg;
    logic                         link_reg;
    logic [31:0]                  tally_reg;

    // Tick state
    logic                         usable_reg;
    logic                         stopping_reg;
    logic [wcwes_pkg::PROD_W-1:0] prod_reg;
    logic                         neg_reg;

    // Output register
    logic                         out_valid_reg;
    logic [28:0]                  frame_id_reg;
    logic [31:0]                  erpm_reg;
    logic [1:0]                   wheel_reg;
    logic                         note_reg;
    logic [31:0]                  count_reg;
    logic                         last_reg;

    logic [31:0]                  age;
    logic                         usable;
    logic [wcwes_pkg::VEL_W-1:0]  vsel;
    logic [wcwes_pkg::VEL_W-1:0]  vmag;
    logic                         vrev;
    logic [wcwes_pkg::PROD_W-1:0] rsum;
    logic [23:0]                  rnd;
    logic [wcwes_pkg::MAX_W-1:0]  mag;
    logic [31:0]                  erpm;
    logic [7:0]                   wheel_id;

    // Configuration writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg    <= wcwes_pkg::RST_ERPM_GAIN;
            max_reg     <= wcwes_pkg::RST_MAX_ABS_ERPM;
            timeout_reg <= wcwes_pkg::RST_TIMEOUT_MS;
            dir_reg     <= wcwes_pkg::RST_DIR_MASK;
            ids_reg     <= wcwes_pkg::RST_WHEEL_IDS;
            ptype_reg   <= wcwes_pkg::RST_PACKET_TYPE;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                wcwes_pkg::CFG_ERPM_GAIN:    gain_reg    <= cfg_data[23:0];
                wcwes_pkg::CFG_MAX_ABS_ERPM: max_reg     <= cfg_data[30:0];
                wcwes_pkg::CFG_TIMEOUT_MS:   timeout_reg <= cfg_data;
                wcwes_pkg::CFG_DIR_MASK:     dir_reg     <= cfg_data[3:0];
                wcwes_pkg::CFG_WHEEL_IDS:    ids_reg     <= cfg_data;
                wcwes_pkg::CFG_PACKET_TYPE:  ptype_reg   <= cfg_data[7:0];
                default:                     ;
            endcase
        end
    end

    // Watchdog: usable when linked, allowed, valid and no older than the timeout
    assign age    = now_ms - time_reg;
    assign usable = link_reg & motion_allowed & received_reg & ok_reg & (age <= timeout_reg);

    // Command store and tick capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < wcwes_pkg::VEL_INPUTS; i++)
            begin
                vel_reg[i] <= '0;
            end
            time_reg     <= '0;
            received_reg <= 1'b0;
            ok_reg       <= 1'b0;
            link_reg     <= 1'b0;
            tally_reg    <= '0;
            usable_reg   <= 1'b0;
            stopping_reg <= 1'b0;
        end
        else if (cmd.take)
        begin
            case (op)
                wcwes_pkg::OP_NEW_CMD:
                begin
                    vel_reg[0]   <= velocity_0;
                    vel_reg[1]   <= velocity_1;
                    vel_reg[2]   <= velocity_2;
                    vel_reg[3]   <= velocity_3;
                    received_reg <= 1'b1;
                    ok_reg       <= command_valid;
                    if (command_valid)
                    begin
                        time_reg <= now_ms;
                    end
                    else
                    begin
                        tally_reg <= tally_reg + 32'd1;
                    end
                end
                wcwes_pkg::OP_INVALIDATE:
                begin
                    for (int i = 0; i < wcwes_pkg::VEL_INPUTS; i++)
                    begin
                        vel_reg[i] <= '0;
                    end
                    time_reg     <= '0;
                    received_reg <= 1'b0;
                    ok_reg       <= 1'b0;
                end
                wcwes_pkg::OP_LINK:
                begin
                    link_reg <= link_up;
                    // Drop the command on disconnect
                    if (!link_up)
                    begin
                        for (int i = 0; i < wcwes_pkg::VEL_INPUTS; i++)
                        begin
                            vel_reg[i] <= '0;
                        end
                        time_reg     <= '0;
                        received_reg <= 1'b0;
                        ok_reg       <= 1'b0;
                    end
                end
                wcwes_pkg::OP_TICK:
                begin
                    usable_reg   <= usable;
                    stopping_reg <= relay_stopping;
                end
                default: ;
            endcase
        end
    end

    // Multiply stage: magnitude of the velocity times the gain
    assign vsel = vel_reg[cmd.wheel];
    assign vmag = vsel[15] ? (~vsel + 16'd1) : vsel;
    assign vrev = dir_reg[cmd.wheel];

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= 40'(vmag) * 40'(gain_reg);
            neg_reg  <= vsel[15] ^ vrev;
        end
    end

    // Finish stage: round, saturate, apply sign, zero when the command is not usable
    assign rsum = prod_reg + wcwes_pkg::ROUND_HALF;
    assign rnd  = rsum[39:16];
    assign mag  = (31'(rnd) > max_reg) ? max_reg : 31'(rnd);
    assign erpm = !usable_reg ? 32'd0 :
                  (neg_reg ? (32'd0 - {1'b0, mag}) : {1'b0, mag});
    assign wheel_id = ids_reg[8*cmd.wheel +: 8];

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            frame_id_reg <= 29'({ptype_reg, wheel_id});
            erpm_reg     <= erpm;
            wheel_reg    <= cmd.wheel;
            note_reg     <= cmd.last & stopping_reg;
            count_reg    <= tally_reg;
            last_reg     <= cmd.last;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign frame_id        = frame_id_reg;
    assign frame_data      = erpm_reg;
    assign signed_erpm     = erpm_reg;
    assign wheel_index     = wheel_reg;
    assign zero_cycle_note = note_reg;
    assign rejected_count  = count_reg;
    assign last            = last_reg;

endmodule

// ===== design/wheel_command_watchdog_erpm_sender.sv =====
// Wheel command watchdog and set-RPM frame sender, top level.
// Joins the controller and datapath. Depends on wcwes_pkg, wcwes_ctrl, wcwes_dp.
//
// Requests on the input channel store a four-wheel command (op 0), invalidate it
// (op 1), update the agent link (op 2) or run a control tick (op 3). Ops 0 to 2
// produce no frames. A tick produces one set-RPM frame per wheel, the final one
// flagged by last; each frame passes through the 16x24 gain multiplier, then
// through rounding, saturation and loading of the output register, and a tick
// holds off the input channel until its last frame is loaded, longer when the
// output channel stalls. The watchdog age test uses the time sampled with the
// tick request. Configuration writes are always ready and should be made only
// while no tick is in progress.
module wheel_command_watchdog_erpm_sender (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic signed [15:0] velocity_0,
    input  logic signed [15:0] velocity_1,
    input  logic signed [15:0] velocity_2,
    input  logic signed [15:0] velocity_3,
    input  logic               command_valid,
    input  logic               link_up,
    input  logic [31:0]        now_ms,
    input  logic               motion_allowed,
    input  logic               relay_stopping,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [28:0]        frame_id,
    output logic [31:0]        frame_data,
    output logic signed [31:0] signed_erpm,
    output logic [1:0]         wheel_index,
    output logic               zero_cycle_note,
    output logic [31:0]        rejected_count,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    wcwes_pkg::ctrl_cmd_t  cmd;
    wcwes_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    wcwes_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    wcwes_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .op              (op),
        .velocity_0      (velocity_0),
        .velocity_1      (velocity_1),
        .velocity_2      (velocity_2),
        .velocity_3      (velocity_3),
        .command_valid   (command_valid),
        .link_up         (link_up),
        .now_ms          (now_ms),
        .motion_allowed  (motion_allowed),
        .relay_stopping  (relay_stopping),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .frame_id        (frame_id),
        .frame_data      (frame_data),
        .signed_erpm     (signed_erpm),
        .wheel_index     (wheel_index),
        .zero_cycle_note (zero_cycle_note),
        .rejected_count  (rejected_count),
        .last            (last)
    );

    // A frame is never loaded over one still waiting to be taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !cmd.load)
        else $error("frame loaded over a pending frame");

    // Frames are produced only while the input channel is held off
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !in_ready)
        else $error("frame loaded while taking requests");

    // An accepted tick holds off the input channel next cycle
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (op == wcwes_pkg::OP_TICK)) |=> !in_ready)
        else $error("tick did not hold off requests");

    // The final frame addresses the last wheel, and only it carries the note
    a_last_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (last || zero_cycle_note)) |->
            (last && (wheel_index == wcwes_pkg::LAST_WHEEL)))
        else $error("final frame flags inconsistent");

endmodule

// ===== tb/tb_wheel_command_watchdog_erpm_sender.sv =====
// Self-checking testbench for the wheel command watchdog and ERPM frame sender.
// Depends on wcwes_pkg and wheel_command_watchdog_erpm_sender; predicts every
// set-RPM frame and compares it field by field.
`timescale 1ns / 100ps

module tb_wheel_command_watchdog_erpm_sender;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int SETTLE_CYCLES    = 16;
    localparam int LONG_HOLD_AT     = 100;
    localparam int LONG_HOLD_CYCLES = 150;

    // Indexes past the register map, written to show they are ignored
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        wcwes_pkg::op_t op;
        logic [15:0] v0;
        logic [15:0] v1;
        logic [15:0] v2;
        logic [15:0] v3;
        logic        cmd_ok;
        logic        link;
        logic [31:0] now;
        logic        allowed;
        logic        stopping;
    } req_t;

    // One directed row: a request and, where pinned, the ERPM typed in per wheel
    typedef struct packed {
        req_t             req;
        logic             pin;
        logic [3:0][31:0] erpm;
    } step_t;

    typedef struct packed {
        logic [28:0] id;
        logic [31:0] data;
        logic [31:0] erpm;
        logic [1:0]  wheel;
        logic        note;
        logic [31:0] rejected;
        logic        fin;
    } frame_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         op;
    logic signed [15:0] velocity_0;
    logic signed [15:0] velocity_1;
    logic signed [15:0] velocity_2;
    logic signed [15:0] velocity_3;
    logic               command_valid;
    logic               link_up;
    logic [31:0]        now_ms;
    logic               motion_allowed;
    logic               relay_stopping;
    logic               out_valid;
    logic               out_ready;
    logic [28:0]        frame_id;
    logic [31:0]        frame_data;
    logic signed [31:0] signed_erpm;
    logic [1:0]         wheel_index;
    logic               zero_cycle_note;
    logic [31:0]        rejected_count;
    logic               last;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    // Predictor copy of the registers
    logic [23:0]        gain_q;
    logic [30:0]        erpm_limit;
    logic [31:0]        age_limit;
    logic [3:0]         flip_mask;
    logic [31:0]        ctrl_ids;
    logic [7:0]         cmd_number;

    // Predictor copy of the held command
    logic [3:0][15:0]   held_vel;
    logic [31:0]        held_time;
    logic               held_present;
    logic               held_good;
    logic               link_state;
    logic [31:0]        bad_cmd_tally;

    frame_t             pending_frames[$];
    int                 mismatches = 0;
    int                 requests = 0;
    int                 ticks = 0;
    int                 frames_seen = 0;
    int                 reg_writes = 0;
    int                 send_burst = 0;
    int                 cycle_count = 0;

    wheel_command_watchdog_erpm_sender dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .velocity_0      (velocity_0),
        .velocity_1      (velocity_1),
        .velocity_2      (velocity_2),
        .velocity_3      (velocity_3),
        .command_valid   (command_valid),
        .link_up         (link_up),
        .now_ms          (now_ms),
        .motion_allowed  (motion_allowed),
        .relay_stopping  (relay_stopping),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .frame_id        (frame_id),
        .frame_data      (frame_data),
        .signed_erpm     (signed_erpm),
        .wheel_index     (wheel_index),
        .zero_cycle_note (zero_cycle_note),
        .rejected_count  (rejected_count),
        .last            (last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Give up on a hung run
    initial
    begin : run_limit
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // Wait length for one request or frame, with stretches of zero
    function automatic int draw_pause(inout int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            burst = $urandom_range(8, 20);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    // Q8.8 rad/s times Q16.8 gain, rounded half away from zero, saturated, signed
    function automatic logic [31:0] scaled_erpm(input logic [15:0] vraw, input logic flip);
        logic        neg;
        logic [16:0] mag;
        logic [40:0] prod;
        logic [40:0] rounded;
        neg = vraw[15];
        mag = neg ? (17'h10000 - {1'b0, vraw}) : {1'b0, vraw};
        prod = mag * gain_q;
        rounded = (prod + wcwes_pkg::ROUND_HALF) >> 16;
        if (rounded > {10'd0, erpm_limit})
            rounded = {10'd0, erpm_limit};
        if (rounded == '0)
            return '0;
        return (neg ^ flip) ? (32'd0 - rounded[31:0]) : rounded[31:0];
    endfunction

    function automatic void drop_command();
        held_vel = '0;
        held_present = 1'b0;
        held_good = 1'b0;
        held_time = '0;
    endfunction

    // Advance the predictor by one accepted request; queue the frames of a tick
    task automatic apply_request(input req_t r, input logic pin, input logic [3:0][31:0] pin_erpm);
        logic [31:0] age;
        logic        usable;
        logic [31:0] erpm;
        frame_t      f;
        case (r.op)
            wcwes_pkg::OP_NEW_CMD:
            begin
                held_vel = {r.v3, r.v2, r.v1, r.v0};
                held_present = 1'b1;
                held_good = r.cmd_ok;
                if (r.cmd_ok)
                    held_time = r.now;
                else
                    bad_cmd_tally = bad_cmd_tally + 32'd1;
            end
            wcwes_pkg::OP_INVALIDATE:
            begin
                drop_command();
            end
            wcwes_pkg::OP_LINK:
            begin
                link_state = r.link;
                if (!r.link)
                    drop_command();
            end
            default:
            begin
                age = r.now - held_time;
                usable = link_state && r.allowed && held_present && held_good &&
                         (age <= age_limit);
                for (int w = 0; w < wcwes_pkg::WHEELS_USED; w++)
                begin
                    erpm = usable ? scaled_erpm(held_vel[w], flip_mask[w]) : '0;
                    if (pin)
                        erpm = pin_erpm[w];
                    f.id = 29'({cmd_number, ctrl_ids[8*w +: 8]});
                    f.data = erpm;
                    f.erpm = erpm;
                    f.wheel = 2'(w);
                    f.fin = (2'(w) == wcwes_pkg::LAST_WHEEL);
                    f.note = f.fin & r.stopping;
                    f.rejected = bad_cmd_tally;
                    pending_frames.push_back(f);
                end
                ticks++;
            end
        endcase
    endtask

    function automatic step_t row(input wcwes_pkg::op_t kind, input logic [15:0] v0, v1, v2, v3,
                                  input logic ok, lk, input logic [31:0] now,
                                  input logic al, st);
        step_t s;
        s = '0;
        s.req.op = kind;
        s.req.v0 = v0;
        s.req.v1 = v1;
        s.req.v2 = v2;
        s.req.v3 = v3;
        s.req.cmd_ok = ok;
        s.req.link = lk;
        s.req.now = now;
        s.req.allowed = al;
        s.req.stopping = st;
        return s;
    endfunction

    function automatic step_t pinned(input step_t s, input logic [31:0] e0, e1, e2, e3);
        s.pin = 1'b1;
        s.erpm = {e3, e2, e1, e0};
        return s;
    endfunction

    function automatic logic [15:0] draw_velocity();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 511) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly ticks and fresh commands with the link up; ages cluster at the timeout
    task automatic draw_request(output req_t r);
        int          pick;
        logic [31:0] age;
        r.v0 = draw_velocity();
        r.v1 = draw_velocity();
        r.v2 = draw_velocity();
        r.v3 = draw_velocity();
        r.cmd_ok = ($urandom_range(0, 7) != 0);
        r.link = ($urandom_range(0, 4) != 0);
        r.now = $urandom;
        r.allowed = ($urandom_range(0, 9) != 0);
        r.stopping = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            r.op = wcwes_pkg::OP_TICK;
            case ($urandom_range(0, 5))
                0: age = '0;
                1: age = age_limit;
                2: age = age_limit + 32'd1;
                3: age = $urandom_range(0, 300);
                default: age = $urandom;
            endcase
            r.now = held_time + age;
        end
        else if (pick < 75)
            r.op = wcwes_pkg::OP_NEW_CMD;
        else if (pick < 83)
            r.op = wcwes_pkg::OP_INVALIDATE;
        else
            r.op = wcwes_pkg::OP_LINK;
    endtask

    // Present one request and hold it until it is taken
    task automatic offer(input req_t r);
        int gap;
        gap = draw_pause(send_burst);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op <= r.op;
        velocity_0 <= r.v0;
        velocity_1 <= r.v1;
        velocity_2 <= r.v2;
        velocity_3 <= r.v3;
        command_valid <= r.cmd_ok;
        link_up <= r.link;
        now_ms <= r.now;
        motion_allowed <= r.allowed;
        relay_stopping <= r.stopping;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        requests++;
    endtask

    // Drop valid, let every predicted frame drain, then let the block settle
    task automatic quiesce();
        in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            wcwes_pkg::CFG_ERPM_GAIN:    gain_q = val[23:0];
            wcwes_pkg::CFG_MAX_ABS_ERPM: erpm_limit = val[30:0];
            wcwes_pkg::CFG_TIMEOUT_MS:   age_limit = val;
            wcwes_pkg::CFG_DIR_MASK:     flip_mask = val[3:0];
            wcwes_pkg::CFG_WHEEL_IDS:    ctrl_ids = val;
            wcwes_pkg::CFG_PACKET_TYPE:  cmd_number = val[7:0];
            default:                     ;
        endcase
    endtask

    task automatic set_regs(input logic [31:0] gain, lim, tmo, mask, ids, ptype);
        quiesce();
        write_reg(wcwes_pkg::CFG_ERPM_GAIN, gain);
        write_reg(wcwes_pkg::CFG_MAX_ABS_ERPM, lim);
        write_reg(wcwes_pkg::CFG_TIMEOUT_MS, tmo);
        write_reg(wcwes_pkg::CFG_DIR_MASK, mask);
        write_reg(wcwes_pkg::CFG_WHEEL_IDS, ids);
        write_reg(wcwes_pkg::CFG_PACKET_TYPE, ptype);
    endtask

    task automatic run_random(input int count);
        req_t r;
        repeat (count)
        begin
            draw_request(r);
            offer(r);
            apply_request(r, 1'b0, '0);
        end
    endtask

    task automatic compare_field(input string what, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
        end
    endtask

    // Frame sink: random stalls plus one long hold-off to back the block up
    initial
    begin : frame_sink
        int     pause;
        int     burst;
        frame_t want;
        burst = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (frames_seen == LONG_HOLD_AT)
                pause = LONG_HOLD_CYCLES;
            else
                pause = draw_pause(burst);
            if (pause > 0)
            begin
                out_ready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            frames_seen++;
            if (pending_frames.size() == 0)
            begin
                mismatches++;
                $display("%0t: frame expected none actual id %0h erpm %0h", $time,
                         frame_id, signed_erpm);
            end
            else
            begin
                want = pending_frames.pop_front();
                compare_field("frame_id", 32'(want.id), 32'(frame_id));
                compare_field("frame_data", want.data, frame_data);
                compare_field("signed_erpm", want.erpm, signed_erpm);
                compare_field("wheel_index", 32'(want.wheel), 32'(wheel_index));
                compare_field("zero_cycle_note", 32'(want.note), 32'(zero_cycle_note));
                compare_field("rejected_count", want.rejected, rejected_count);
                compare_field("last", 32'(want.fin), 32'(last));
            end
        end
    end

    // Request source: reset, directed table, then randomized phases per setting
    initial
    begin : request_source
        step_t directed[$];
        step_t s;

        rst_n <= 1'b0;
        in_valid <= 1'b0;
        op <= wcwes_pkg::OP_NEW_CMD;
        velocity_0 <= '0;
        velocity_1 <= '0;
        velocity_2 <= '0;
        velocity_3 <= '0;
        command_valid <= 1'b0;
        link_up <= 1'b0;
        now_ms <= '0;
        motion_allowed <= 1'b0;
        relay_stopping <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= wcwes_pkg::CFG_ERPM_GAIN;
        cfg_data <= '0;

        gain_q = wcwes_pkg::RST_ERPM_GAIN;
        erpm_limit = wcwes_pkg::RST_MAX_ABS_ERPM;
        age_limit = wcwes_pkg::RST_TIMEOUT_MS;
        flip_mask = wcwes_pkg::RST_DIR_MASK;
        ctrl_ids = wcwes_pkg::RST_WHEEL_IDS;
        cmd_number = wcwes_pkg::RST_PACKET_TYPE;
        drop_command();
        link_state = 1'b0;
        bad_cmd_tally = '0;

        // Tick after reset, link down: all zero
        directed.push_back(pinned(row(wcwes_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 32'd0, 1, 0),
                                  0, 0, 0, 0));
        directed.push_back(row(wcwes_pkg::OP_LINK, 0, 0, 0, 0, 0, 1, 32'd0, 0, 0));
        // Velocity extremes and the half-ERPM rounding point at unity gain
        directed.push_back(row(wcwes_pkg::OP_NEW_CMD, 32767, -32768, 128, -128, 1, 0,
                               32'd1000, 0, 0));
        directed.push_back(pinned(row(wcwes_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 32'd1000, 1, 0),
                                  128, -128, 1, -1));
        // Age exactly at the timeout still drives; relay stopping on the last frame
        directed.push_back(pinned(row(wcwes_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 32'd1200, 1, 1),
                                  128, -128, 1, -1));
        // One past the timeout, then motion not allowed
        directed.push_back(pinned(row(wcwes_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 32'd1201, 1, 0),
                                  0, 0, 0, 0));
        directed.push_back(pinned(row(wcwes_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 32'd1100, 0, 0),
                                  0, 0, 0, 0));
        // Command marked invalid: stored, counted, never driven
        directed.push_back(row(wcwes_pkg::OP_NEW_CMD, 127, -127, 0, 256, 0, 0, 32'd5, 0, 0));
        directed.push_back(pinned(row(wcwes_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 32'd1000, 1, 0),
                                  0, 0, 0, 0));
        // Age test across the 32-bit wrap; just under half rounds to zero
        directed.push_back(row(wcwes_pkg::OP_NEW_CMD, 127, -127, 0, 256, 1, 0,
                               32'hFFFF_FF9C, 0, 0));
        directed.push_back(pinned(row(wcwes_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 32'd50, 1, 0),
                                  0, 0, 0, 1));
        // Invalidate clears the command
        directed.push_back(row(wcwes_pkg::OP_INVALIDATE, 0, 0, 0, 0, 0, 0, 32'd0, 0, 0));
        directed.push_back(pinned(row(wcwes_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 32'd50, 1, 0),
                                  0, 0, 0, 0));
        // Disconnect clears it too, and reconnecting does not restore it
        directed.push_back(row(wcwes_pkg::OP_NEW_CMD, 256, 256, 256, 256, 1, 0, 32'd60, 0, 0));
        directed.push_back(row(wcwes_pkg::OP_LINK, 0, 0, 0, 0, 0, 0, 32'd0, 0, 0));
        directed.push_back(row(wcwes_pkg::OP_LINK, 0, 0, 0, 0, 0, 1, 32'd0, 0, 0));
        directed.push_back(pinned(row(wcwes_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 32'd60, 1, 0),
                                  0, 0, 0, 0));
        // Connect while connected keeps the command; wrapped age of exactly the timeout
        directed.push_back(row(wcwes_pkg::OP_NEW_CMD, -256, -384, 384, -32767, 1, 0,
                               32'hFFFF_FFFF, 0, 0));
        directed.push_back(row(wcwes_pkg::OP_LINK, 0, 0, 0, 0, 0, 1, 32'd0, 0, 0));
        directed.push_back(pinned(row(wcwes_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 32'd199, 1, 1),
                                  -1, -2, 2, -128));
        directed.push_back(pinned(row(wcwes_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 32'd200, 1, 0),
                                  0, 0, 0, 0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (directed[i])
        begin
            s = directed[i];
            offer(s.req);
            apply_request(s.req, s.pin, s.erpm);
        end

        // Fully random setting, plus writes to indexes outside the map
        set_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        write_reg(CFG_SPARE_LO, $urandom);
        write_reg(CFG_SPARE_HI, $urandom);
        run_random(40);

        // Every register at its top value
        set_regs('1, '1, '1, '1, '1, '1);
        run_random(35);

        // Every register at zero: only a zero-age command is fresh
        set_regs('0, '0, '0, '0, '0, '0);
        run_random(25);

        // Small gains and limits, short timeouts: rounding and saturation
        set_regs($urandom_range(0, 32'h3FFF), $urandom_range(0, 20000), $urandom_range(0, 500),
                 $urandom, $urandom, $urandom);
        run_random(35);

        // Back to the reset setting
        set_regs(wcwes_pkg::RST_ERPM_GAIN, wcwes_pkg::RST_MAX_ABS_ERPM,
                 wcwes_pkg::RST_TIMEOUT_MS, wcwes_pkg::RST_DIR_MASK,
                 wcwes_pkg::RST_WHEEL_IDS, wcwes_pkg::RST_PACKET_TYPE);
        run_random(25);

        quiesce();
        $display("run covered %0d requests (%0d ticks) and %0d register writes", requests,
                 ticks, reg_writes);
        $display("%0d frames compared across six register settings, %0d mismatches",
                 frames_seen, mismatches);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
